// File: rtl/core/ohvd_pkg.sv
// Shared constants, types and coordinate classification for the vertex dedup core.
package ohvd_pkg;

   localparam int NUM_BUCKETS  = 8;
   localparam int BUCKET_W     = 3;
   localparam int BUCKET_DEPTH = 256;
   localparam int LOCAL_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int FILL_W       = $clog2(BUCKET_DEPTH + 1);
   localparam int BASE_W       = $clog2(NUM_BUCKETS * BUCKET_DEPTH + 1);
   localparam int STORE_W      = 96;
   localparam int STORE_DEPTH  = NUM_BUCKETS << LOCAL_W;
   localparam int STORE_AW     = BUCKET_W + LOCAL_W;

   localparam logic [1:0] OP_INSERT    = 2'd0;
   localparam logic [1:0] OP_LOOKUP    = 2'd1;
   localparam logic [1:0] OP_CLEAR     = 2'd2;
   localparam int         OP_CLEAR_BIT = 1;

   typedef enum logic [2:0] {
      ST_NEW       = 3'd0,
      ST_PRESENT   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_INVALID   = 3'd4,
      ST_CLEARED   = 3'd5
   } status_type;

   function automatic logic is_nan(input logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   // Float test b >= 0.0, where negative zero passes and NaN fails.
   function automatic logic ge_zero(input logic [31:0] b);
      return !is_nan(b) && (!b[31] || (b[30:0] == 31'd0));
   endfunction

   function automatic logic [BUCKET_W-1:0] octant(input logic [31:0] x,
                                                  input logic [31:0] y,
                                                  input logic [31:0] z);
      logic [1:0] quad;
      logic       xp;
      logic       yp;
      xp = ge_zero(x);
      yp = ge_zero(y);
      if (yp) begin
         quad = xp ? 2'd0 : 2'd1;
      end else begin
         quad = xp ? 2'd3 : 2'd2;
      end
      return {ge_zero(z), quad};
   endfunction

endpackage

// File: rtl/core/ohvd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ohvd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/octant_hashed_vertex_dedup_core.sv
// Top level of the octant-bucketed vertex deduplication core.
//
// Each request carries one vertex as three float bit patterns and an operation (insert,
// look up or clear). The vertex is sorted into one of eight octant buckets, and the bucket
// is searched for an exact bitwise match in one vertex RAM, one stored entry per cycle
// through its single read port. An insert or lookup first sums the entry counts of the lower
// buckets to find the base of its bucket, then scans the entries of that bucket, at most 256,
// until a match turns up or the entries run out. Clear and invalid-coordinate requests skip
// the summing and the scan. No request is taken while one is in progress, but a new
// request is accepted while the previous response still waits in the output register. The
// bucket counts reset to zero at once, so no clearing pass is needed after reset.
module octant_hashed_vertex_dedup_core
   import ohvd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_x_bits,
   input  logic [31:0] req_y_bits,
   input  logic [31:0] req_z_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_bucket,
   output logic [7:0]  rsp_local_index,
   output logic [10:0] rsp_global_index
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLASSIFY,
      S_BASE,
      S_SCAN,
      S_RESULT
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [31:0]           x_ff, x_in;
   logic [31:0]           y_ff, y_in;
   logic [31:0]           z_ff, z_in;
   logic [BUCKET_W-1:0]   bk_ff, bk_in;
   logic [BUCKET_W-1:0]   idx_ff, idx_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [FILL_W-1:0]     fill_cur_ff, fill_cur_in;
   logic [FILL_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [FILL_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [FILL_W-1:0]     fill_ff [NUM_BUCKETS];
   logic [FILL_W-1:0]     fill_in [NUM_BUCKETS];
   status_type            res_status_ff, res_status_in;
   logic [FILL_W-1:0]     res_local_ff, res_local_in;
   logic [BASE_W-1:0]     res_global_ff, res_global_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [2:0]            rsp_bucket_ff, rsp_bucket_in;
   logic [7:0]            rsp_local_ff, rsp_local_in;
   logic [10:0]           rsp_global_ff, rsp_global_in;

   logic                  issue;
   logic                  match;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [STORE_AW-1:0]   ram_wr_addr;
   logic [STORE_AW-1:0]   ram_rd_addr;
   logic [STORE_W-1:0]    ram_rd_data;
   logic [31:0]           local_wide;
   logic [31:0]           global_wide;

   ohvd_ram #(
      .WIDTH (STORE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({x_ff, y_ff, z_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign issue       = rd_cnt_ff < fill_cur_ff;
   assign match       = ram_rd_data == {x_ff, y_ff, z_ff};
   assign ram_rd_en   = (state_ff == S_SCAN) && issue;
   assign ram_rd_addr = {bk_ff, rd_cnt_ff[LOCAL_W-1:0]};
   assign ram_wr_addr = {bk_ff, fill_cur_ff[LOCAL_W-1:0]};
   assign local_wide  = 32'(res_local_ff);
   assign global_wide = 32'(res_global_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      bk_in         = bk_ff;
      idx_in        = idx_ff;
      base_in       = base_ff;
      fill_cur_in   = fill_cur_ff;
      rd_cnt_in     = rd_cnt_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      fill_in       = fill_ff;
      res_status_in = res_status_ff;
      res_local_in  = res_local_ff;
      res_global_in = res_global_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_local_in  = rsp_local_ff;
      rsp_global_in = rsp_global_ff;
      ram_wr_en     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               x_in     = req_x_bits;
               y_in     = req_y_bits;
               z_in     = req_z_bits;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            res_local_in  = '0;
            res_global_in = '0;
            idx_in        = '0;
            base_in       = '0;
            if (op_ff[OP_CLEAR_BIT]) begin
               for (int b = 0; b < NUM_BUCKETS; b++) begin
                  fill_in[b] = '0;
               end
               res_status_in = ST_CLEARED;
               bk_in         = '0;
               state_in      = S_RESULT;
            end else if (is_nan(x_ff) || is_nan(y_ff)) begin
               res_status_in = ST_INVALID;
               bk_in         = '0;
               state_in      = S_RESULT;
            end else begin
               bk_in    = octant(x_ff, y_ff, z_ff);
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            if (idx_ff == bk_ff) begin
               fill_cur_in = fill_ff[idx_ff];
               rd_cnt_in   = '0;
               cmp_vld_in  = 1'b0;
               state_in    = S_SCAN;
            end else begin
               base_in = base_ff + BASE_W'(fill_ff[idx_ff]);
               idx_in  = idx_ff + 1'b1;
            end
         end
         S_SCAN: begin
            if (cmp_vld_ff && match) begin
               res_status_in = ST_PRESENT;
               res_local_in  = cmp_idx_ff;
               res_global_in = base_ff + BASE_W'(cmp_idx_ff);
               state_in      = S_RESULT;
            end else if (!issue && !cmp_vld_ff) begin
               state_in = S_RESULT;
               if (op_ff == OP_LOOKUP) begin
                  res_status_in = ST_NOT_FOUND;
               end else if (fill_cur_ff >= FILL_W'(BUCKET_DEPTH)) begin
                  res_status_in = ST_FULL;
               end else begin
                  ram_wr_en      = 1'b1;
                  fill_in[bk_ff] = fill_cur_ff + 1'b1;
                  res_status_in  = ST_NEW;
                  res_local_in   = fill_cur_ff;
                  res_global_in  = base_ff + BASE_W'(fill_cur_ff);
               end
            end else begin
               cmp_vld_in = issue;
               cmp_idx_in = rd_cnt_ff;
               if (issue) begin
                  rd_cnt_in = rd_cnt_ff + 1'b1;
               end
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_bucket_in = bk_ff;
               rsp_local_in  = local_wide[7:0];
               rsp_global_in = global_wide[10:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         fill_ff      <= fill_in;
      end
      op_ff         <= op_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      bk_ff         <= bk_in;
      idx_ff        <= idx_in;
      base_ff       <= base_in;
      fill_cur_ff   <= fill_cur_in;
      rd_cnt_ff     <= rd_cnt_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_local_ff  <= res_local_in;
      res_global_ff <= res_global_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_local_ff  <= rsp_local_in;
      rsp_global_ff <= rsp_global_in;
   end

   assign req_ready        = state_ff == S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bucket       = rsp_bucket_ff;
   assign rsp_local_index  = rsp_local_ff;
   assign rsp_global_index = rsp_global_ff;

endmodule

// File: verif/octant_hashed_vertex_dedup_checker.sv
// Checker that predicts and compares every response of the vertex dedup core.
`timescale 1ns / 100ps

module octant_hashed_vertex_dedup_checker
   import ohvd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_operation,
   input  logic [31:0]       req_x_bits,
   input  logic [31:0]       req_y_bits,
   input  logic [31:0]       req_z_bits,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [2:0]        rsp_status,
   input  logic [2:0]        rsp_bucket,
   input  logic [7:0]        rsp_local_index,
   input  logic [10:0]       rsp_global_index,
   output int unsigned       fail_count,
   output int unsigned       pending_count
);

   typedef struct packed {
      status_type  status;
      logic [2:0]  bucket;
      logic [7:0]  local_index;
      logic [10:0] global_index;
   } dedup_outcome_type;

   logic [95:0]       vertex_mem [NUM_BUCKETS][BUCKET_DEPTH];
   int unsigned       fill_count [NUM_BUCKETS];
   dedup_outcome_type pending_outcomes [$];
   int unsigned       mismatches = 0;
   int unsigned       outstanding = 0;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;

   function automatic bit coord_is_nan(input logic [31:0] b);
      return b[30:0] > 31'h7F80_0000;
   endfunction

   function automatic bit coord_nonneg(input logic [31:0] b);
      return !coord_is_nan(b) && (!b[31] || b[30:0] == 31'd0);
   endfunction

   function automatic dedup_outcome_type predict_outcome(input logic [1:0]  op,
                                                         input logic [31:0] x,
                                                         input logic [31:0] y,
                                                         input logic [31:0] z);
      dedup_outcome_type r;
      logic [2:0]        bk;
      int unsigned       base;
      int unsigned       fill;
      int unsigned       hit;
      bit                found;
      r = '0;
      if (op[OP_CLEAR_BIT]) begin
         foreach (fill_count[b]) fill_count[b] = 0;
         r.status = ST_CLEARED;
      end else if (coord_is_nan(x) || coord_is_nan(y)) begin
         r.status = ST_INVALID;
      end else begin
         bk[2] = coord_nonneg(z);
         bk[1] = !coord_nonneg(y);
         bk[0] = coord_nonneg(x) ^ coord_nonneg(y);
         base = 0;
         for (int b = 0; b < bk; b++) base += fill_count[b];
         fill = fill_count[bk];
         found = 0;
         hit = 0;
         for (int i = 0; i < fill; i++) begin
            if (!found && vertex_mem[bk][i] == {x, y, z}) begin
               found = 1;
               hit = i;
            end
         end
         r.bucket = bk;
         if (found) begin
            r.status       = ST_PRESENT;
            r.local_index  = 8'(hit);
            r.global_index = 11'(base + hit);
         end else if (op == OP_LOOKUP) begin
            r.status = ST_NOT_FOUND;
         end else if (fill >= BUCKET_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            vertex_mem[bk][fill] = {x, y, z};
            fill_count[bk] = fill + 1;
            r.status       = ST_NEW;
            r.local_index  = 8'(fill);
            r.global_index = 11'(base + fill);
         end
      end
      return r;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : track
      dedup_outcome_type want;
      if (reset) begin
         foreach (fill_count[b]) fill_count[b] = 0;
         pending_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: response with no transaction outstanding, status %0d",
                        $time, rsp_status);
            end else begin
               want = pending_outcomes.pop_front();
               compare_field("status", want.status, rsp_status);
               compare_field("bucket", want.bucket, rsp_bucket);
               compare_field("local_index", want.local_index, rsp_local_index);
               compare_field("global_index", want.global_index, rsp_global_index);
            end
         end
         if (req_valid && req_ready) begin
            pending_outcomes.push_back(predict_outcome(req_operation, req_x_bits,
                                                       req_y_bits, req_z_bits));
         end
      end
      outstanding = pending_outcomes.size();
   end

endmodule

// File: verif/octant_hashed_vertex_dedup_core_tb.sv
// Testbench top for the vertex dedup core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module octant_hashed_vertex_dedup_core_tb
   import ohvd_pkg::*;
;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 300;
   localparam int RANDOM_ITEMS    = 1600;
   localparam int HOLD_OFF_AT     = 300;
   localparam int HOLD_OFF_CYCLES = 700;

   localparam logic [31:0] F_POS_ONE  = 32'h3F80_0000;
   localparam logic [31:0] F_NEG_ONE  = 32'hBF80_0000;
   localparam logic [31:0] F_POS_ZERO = 32'h0000_0000;
   localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
   localparam logic [31:0] F_POS_INF  = 32'h7F80_0000;
   localparam logic [31:0] F_NEG_INF  = 32'hFF80_0000;
   localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation    = OP_INSERT;
   logic [31:0] req_x_bits       = '0;
   logic [31:0] req_y_bits       = '0;
   logic [31:0] req_z_bits       = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_bucket;
   logic [7:0]  rsp_local_index;
   logic [10:0] rsp_global_index;
   int unsigned fail_count;
   int unsigned pending_count;

   logic [95:0] vertex_pool [$];
   bit          burst_send = 0;
   bit          burst_recv = 0;
   int unsigned sent_count = 0;
   int unsigned idle_cycles = 0;

   octant_hashed_vertex_dedup_core uut (.*);

   octant_hashed_vertex_dedup_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] nan_bits();
      return {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
   endfunction

   function automatic logic [31:0] random_coord(input bit nan_ok);
      int unsigned sel;
      logic [31:0] v;
      sel = $urandom_range(0, nan_ok ? 9 : 8);
      case (sel)
         5: v = {1'($urandom), 31'd0};
         6: v = {1'($urandom), 8'hFF, 23'd0};
         7: v = {1'($urandom), F_POS_ONE[30:0]};
         8: v = {1'($urandom), 8'($urandom_range(124, 130)), 23'd0};
         9: v = nan_bits();
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic offer_item(input logic [1:0] op, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
      int unsigned gap;
      if (sent_count % 48 == 0) burst_send = ($urandom_range(0, 3) == 0);
      gap = burst_send ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_x_bits    <= x;
      req_y_bits    <= y;
      req_z_bits    <= z;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   initial begin
      int unsigned wait_cycles;
      int unsigned got;
      got = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (got % 40 == 0) burst_recv = ($urandom_range(0, 3) == 0);
         if (got == HOLD_OFF_AT) wait_cycles = HOLD_OFF_CYCLES;
         else wait_cycles = burst_recv ? 0 : $urandom_range(0, 13);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [1:0]  op;
      logic [31:0] fx;
      logic [31:0] fy;
      logic [31:0] fz;
      logic [95:0] vtx;
      int unsigned sel;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      offer_item(OP_INSERT, F_POS_ZERO, F_POS_ZERO, F_POS_ZERO);
      offer_item(OP_INSERT, F_NEG_ZERO, F_NEG_ZERO, F_NEG_ZERO);
      offer_item(OP_INSERT, F_POS_ZERO, F_POS_ZERO, F_POS_ZERO);
      offer_item(OP_LOOKUP, F_NEG_ZERO, F_NEG_ZERO, F_NEG_ZERO);
      offer_item(OP_LOOKUP, F_POS_ONE, F_POS_ONE, F_POS_ONE);
      offer_item(OP_INSERT, F_NEG_ONE, F_POS_ONE, F_NEG_ONE);
      offer_item(OP_INSERT, F_NEG_ONE, F_NEG_ONE, F_NEG_ONE);
      offer_item(OP_INSERT, F_POS_ONE, F_NEG_ONE, F_NEG_ONE);
      offer_item(OP_INSERT, F_POS_ONE, F_POS_ONE, F_NEG_ONE);
      offer_item(OP_INSERT, F_POS_INF, F_NEG_INF, F_POS_INF);
      offer_item(OP_INSERT, F_QNAN, F_POS_ONE, F_POS_ONE);
      offer_item(OP_LOOKUP, F_POS_ONE, 32'hFFFF_FFFF, F_POS_ONE);
      offer_item(OP_INSERT, 32'h0000_0001, 32'h0000_0001, 32'h7FC0_0001);
      offer_item(OP_LOOKUP, 32'h0000_0001, 32'h0000_0001, 32'h7FC0_0001);
      offer_item(OP_INSERT, 32'h8000_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF);
      offer_item(OP_INSERT, F_POS_ZERO, F_NEG_ZERO, 32'hFFFF_FFFF);
      offer_item(OP_INSERT, 32'h7F80_0001, F_POS_ZERO, F_POS_ZERO);
      offer_item(OP_LOOKUP, F_POS_INF, F_NEG_INF, F_POS_INF);
      offer_item(OP_CLEAR | OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_item(OP_LOOKUP, F_POS_ZERO, F_POS_ZERO, F_POS_ZERO);
      offer_item(OP_INSERT, F_POS_ZERO, F_POS_ZERO, F_POS_ZERO);
      offer_item(OP_CLEAR, F_POS_ZERO, F_POS_ZERO, F_POS_ZERO);

      // Fill one bucket to capacity, then push it past the limit.
      wait_for_drain();
      fx = '0;
      fy = '0;
      fz = '0;
      for (int k = 0; k < BUCKET_DEPTH; k++) begin
         fx = 32'hC000_0000 + k;
         fy = 32'h8000_0001 + ($urandom & 32'h3FFF_FFFF);
         fz = $urandom & 32'h7F7F_FFFF;
         offer_item(OP_INSERT, fx, fy, fz);
      end
      offer_item(OP_LOOKUP, fx, fy, fz);
      offer_item(OP_INSERT, fx, fy, fz);
      for (int j = 0; j < 3; j++) offer_item(OP_INSERT, 32'hC100_0000 + j, F_NEG_ONE, F_POS_ONE);
      offer_item(OP_INSERT, F_POS_ONE, F_NEG_ONE, F_POS_ONE);
      offer_item(OP_INSERT, F_POS_ONE, F_POS_ONE, F_NEG_ONE);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) wait_for_drain();
         sel = $urandom_range(0, 199);
         vtx = {random_coord(0), random_coord(0), random_coord(1)};
         if (sel < 2) begin
            op = OP_CLEAR;
            op[0] = 1'($urandom);
            vertex_pool.delete();
            vtx = {$urandom, $urandom, $urandom};
         end else if (sel < 20) begin
            op = $urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT;
            if ($urandom_range(0, 1)) vtx[95:64] = nan_bits();
            else vtx[63:32] = nan_bits();
         end else begin
            op = (sel < 120) ? OP_INSERT : OP_LOOKUP;
            if (vertex_pool.size() > 0 && $urandom_range(0, 9) < 6) begin
               vtx = vertex_pool[$urandom_range(0, vertex_pool.size() - 1)];
            end else if (op == OP_INSERT) begin
               vertex_pool.push_back(vtx);
               if (vertex_pool.size() > 128) void'(vertex_pool.pop_front());
            end
         end
         offer_item(op, vtx[95:64], vtx[63:32], vtx[31:0]);
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/ohvd_pkg.sv
rtl/core/ohvd_ram.sv
rtl/core/octant_hashed_vertex_dedup_core.sv
verif/octant_hashed_vertex_dedup_checker.sv
verif/octant_hashed_vertex_dedup_core_tb.sv
